[rtl/multi_queue_priority_dispatch_unit_assert.svh]
// ----------------------------------------------------------------------------
// multi_queue_priority_dispatch_unit assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_PRIORITY_DISPATCH_UNIT_ASSERT_SVH
`define MULTI_QUEUE_PRIORITY_DISPATCH_UNIT_ASSERT_SVH

// same-cycle implication
`define MQPD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mqpd assertion failed");

// next-cycle implication
`define MQPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mqpd assertion failed");

`endif

[rtl/mqpd_pkg.sv]
// ----------------------------------------------------------------------------
// mqpd_pkg
// shared types and constants of the priority dispatch unit
// ----------------------------------------------------------------------------
package mqpd_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 1024;
    localparam int ID_W  = 10;
    localparam int SRV_W = 2;
    localparam int PRI_W = 4;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_SERVE  = 1'b1;

    localparam logic [SRV_W-1:0] SRV_ZERO = 2'd0;
    localparam logic [SRV_W-1:0] SRV_LAST = 2'd3;

    typedef struct packed {
        logic [SRV_W-1:0] srv;
        logic [PRI_W-1:0] pri;
    } entry_t;

    // server code zero behaves as server three
    function automatic logic [SRV_W-1:0] norm_server(input logic [SRV_W-1:0] s);
        norm_server = (s == SRV_ZERO) ? SRV_LAST : s;
    endfunction

endpackage

[rtl/multi_queue_priority_dispatch_unit.sv]
// ----------------------------------------------------------------------------
// multi_queue_priority_dispatch_unit
// three server queues in one entry store, served by priority, oldest first
// ----------------------------------------------------------------------------
// usage
//   command channel: a beat is taken on a rising edge with start high and
//   busy low; kind selects arrival or serve, server picks the queue
//   (code zero acts as server three), priority_req is used on arrival only
//   arrival: written to the store in the accept cycle, busy stays low, so
//   arrivals can follow back to back; no result beat; ignored once the
//   store holds MAX_ENTRIES-1 ids
//   serve: the store is swept once over ids 1 .. next_id-1, one read per
//   cycle through the single read port; busy is high through the scan and
//   drain states (drain alone with an empty store), the winner is cleared in
//   the drain state and the result beat appears in the cycle after
//   result channel: done marks served_id / empty_res for exactly one cycle;
//   the receiver cannot stall, and a new command may be taken while the
//   result beat is on the ports
//   reset: next id returns to 1; store contents need no clearing since
//   only ids below next id are ever read
// ----------------------------------------------------------------------------
`include "multi_queue_priority_dispatch_unit_assert.svh"

module multi_queue_priority_dispatch_unit
    import mqpd_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             kind,
    input  logic [SRV_W-1:0] server,
    input  logic [PRI_W-1:0] priority_req,
    output logic             done,
    output logic [ID_W-1:0]  served_id,
    output logic             empty_res
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int NID_W = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    // id counter, can reach MAX_ENTRIES when full
    logic [NID_W-1:0] next_id_reg, next_id_next;

    // scan bookkeeping
    logic [IDX_W-1:0] issue_addr_reg, issue_addr_next;
    logic [IDX_W-1:0] rd_id_reg, rd_id_next;
    logic             rd_valid_reg, rd_valid_next;
    logic [SRV_W-1:0] srv_reg, srv_next;
    logic [IDX_W-1:0] best_id_reg, best_id_next;
    logic [PRI_W-1:0] best_pri_reg, best_pri_next;

    // result registers
    logic             done_reg, done_next;
    logic [ID_W-1:0]  served_id_reg, served_id_next;
    logic             empty_res_reg, empty_res_next;

    // store ports
    logic             st_wr_en;
    logic [IDX_W-1:0] st_wr_addr;
    entry_t           st_wr_data;
    logic             st_rd_en;
    logic [IDX_W-1:0] st_rd_addr;
    entry_t           st_rd_data;

    // running best including the entry just read
    logic [IDX_W-1:0]        cand_id;
    logic [PRI_W-1:0]        cand_pri;
    logic [NID_W-1:0]        last_id;
    logic [IDX_W+ID_W-1:0]   cand_id_wide;

    mqpd_store #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    assign last_id = next_id_reg - NID_W'(1);

    // strict greater keeps the lowest id among equal priorities
    always_comb
    begin
        cand_id  = best_id_reg;
        cand_pri = best_pri_reg;
        if (rd_valid_reg && (st_rd_data.srv == srv_reg) &&
            (st_rd_data.pri != '0) && (st_rd_data.pri > best_pri_reg))
        begin
            cand_id  = rd_id_reg;
            cand_pri = st_rd_data.pri;
        end
    end

    // ids wider than the result port are masked to its width
    assign cand_id_wide = {{ID_W{1'b0}}, cand_id};

    always_comb
    begin
        state_next      = state_reg;
        next_id_next    = next_id_reg;
        issue_addr_next = issue_addr_reg;
        rd_id_next      = rd_id_reg;
        rd_valid_next   = 1'b0;
        srv_next        = srv_reg;
        best_id_next    = best_id_reg;
        best_pri_next   = best_pri_reg;
        done_next       = 1'b0;
        served_id_next  = served_id_reg;
        empty_res_next  = empty_res_reg;
        st_wr_en        = 1'b0;
        st_wr_addr      = next_id_reg[IDX_W-1:0];
        st_wr_data      = '{srv: norm_server(server), pri: priority_req};
        st_rd_en        = 1'b0;
        st_rd_addr      = issue_addr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_ARRIVE)
                    begin
                        // full store drops the arrival
                        if (next_id_reg < NID_W'(MAX_ENTRIES))
                        begin
                            st_wr_en     = 1'b1;
                            next_id_next = next_id_reg + NID_W'(1);
                        end
                    end
                    else
                    begin
                        srv_next        = norm_server(server);
                        best_id_next    = '0;
                        best_pri_next   = '0;
                        issue_addr_next = IDX_W'(1);
                        state_next      = (next_id_reg == NID_W'(1)) ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                st_rd_en      = 1'b1;
                rd_id_next    = issue_addr_reg;
                rd_valid_next = 1'b1;
                best_id_next  = cand_id;
                best_pri_next = cand_pri;
                if (issue_addr_reg == last_id[IDX_W-1:0])
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    issue_addr_next = issue_addr_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                // last read folded in via cand_id
                done_next  = 1'b1;
                state_next = ST_IDLE;
                if (cand_id != '0)
                begin
                    st_wr_en       = 1'b1;
                    st_wr_addr     = cand_id;
                    st_wr_data     = '{srv: srv_reg, pri: '0};
                    served_id_next = cand_id_wide[ID_W-1:0];
                    empty_res_next = 1'b0;
                end
                else
                begin
                    served_id_next = '0;
                    empty_res_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, counters and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            next_id_reg   <= NID_W'(1);
            rd_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            served_id_reg <= '0;
            empty_res_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_id_reg   <= next_id_next;
            rd_valid_reg  <= rd_valid_next;
            done_reg      <= done_next;
            served_id_reg <= served_id_next;
            empty_res_reg <= empty_res_next;
        end
    end

    // scan payload, no reset needed
    always_ff @(posedge clk)
    begin
        issue_addr_reg <= issue_addr_next;
        rd_id_reg      <= rd_id_next;
        srv_reg        <= srv_next;
        best_id_reg    <= best_id_next;
        best_pri_reg   <= best_pri_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign served_id = served_id_reg;
    assign empty_res = empty_res_reg;

    // scan never runs past the last issued id
    `MQPD_ASSERT_IMPL(a_scan_in_range, state_reg == ST_SCAN, issue_addr_reg < next_id_reg)
    // store writes only from idle arrivals or the clear at scan end
    `MQPD_ASSERT_IMPL(a_wr_slot, st_wr_en, state_reg == ST_IDLE || state_reg == ST_DRAIN)
    // a result beat is never followed by another in the next cycle
    `MQPD_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    // id counter stays in its range
    `MQPD_ASSERT_IMPL(a_next_id_range, 1'b1,
        next_id_reg != '0 && next_id_reg <= NID_W'(MAX_ENTRIES))

endmodule

[rtl/mqpd_store.sv]
// ----------------------------------------------------------------------------
// mqpd_store
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mqpd_store
    import mqpd_pkg::*;
#(
    parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES,
    localparam int IDX_W = $clog2(MAX_ENTRIES)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
